// ----- src/eecs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder edge counter and speed meter: shared package
// Action codes, constants and the control/status structs between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package eecs_pkg;

  typedef enum logic [1:0] {
    ACT_CAPTURE = 2'd0,
    ACT_SET_POS = 2'd1,
    ACT_STOP    = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic [15:0] PERIOD_LIMIT    = 16'h7FFF;
  localparam logic [15:0] NUMERATOR_RESET = 16'd32766;

  typedef struct packed {
    logic update;    // apply the accepted beat to the meter state
    logic div_load;  // start a division of the numerator by the period
    logic div_step;  // one restoring step
    logic out_load;  // capture the result into the output register
  } ctrl_t;

  typedef struct packed {
    logic div_last;  // the step taken this cycle is the final one
  } stat_t;

endpackage

// ----- src/eecs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder meter channels
// Valid/ready channels for event beats and result beats.
// ----------------------------------------------------------------------------
interface eecs_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] captured_period;
  logic        dir_pin;
  logic signed [15:0] new_position;

  modport source (output valid, action, captured_period, dir_pin, new_position,
                  input ready);
  modport sink   (input valid, action, captured_period, dir_pin, new_position,
                  output ready);
endinterface

interface eecs_result_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] position;
  logic signed [15:0] signed_period;
  logic signed [16:0] speed;
  logic        is_stopped;

  modport source (output valid, position, signed_period, speed, is_stopped,
                  input ready);
  modport sink   (input valid, position, signed_period, speed, is_stopped,
                  output ready);
endinterface

// ----- src/eecs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder meter controller
// Sequences state update, division and result hand-off.
// ----------------------------------------------------------------------------
module eecs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  eecs_pkg::stat_t stat,
  output eecs_pkg::ctrl_t ctrl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_HOLD
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    ctrl = '0;
    case (state)
      S_IDLE:  ctrl.update   = in_valid;
      S_LOAD:  ctrl.div_load = 1'b1;
      S_DIV:   ctrl.div_step = 1'b1;
      S_HOLD:  ctrl.out_load = out_free;
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_LOAD;
        end
        S_LOAD: state <= S_DIV;
        S_DIV: begin
          if (stat.div_last) state <= S_HOLD;
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/eecs_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder meter datapath
// Meter state, restoring radix-2 divider and the result register.
// ----------------------------------------------------------------------------
module eecs_dp (
  input  logic               clk,
  input  logic               rst,
  input  eecs_pkg::ctrl_t    ctrl,
  output eecs_pkg::stat_t    stat,
  input  logic               numerator_we,
  input  logic [15:0]        numerator_wdata,
  input  logic [1:0]         action,
  input  logic [15:0]        captured_period,
  input  logic               dir_pin,
  input  logic signed [15:0] new_position,
  output logic signed [15:0] position,
  output logic signed [15:0] signed_period,
  output logic signed [16:0] speed,
  output logic               is_stopped
);

  logic [15:0] numerator;
  logic [23:0] tick_count;
  logic [15:0] last_period;
  logic        last_direction;
  logic        meter_valid;
  logic        stopped_mark;

  logic [15:0] rem;
  logic [15:0] quo;
  logic [eecs_pkg::STEP_W-1:0] step_cnt;

  logic [16:0] shifted;
  logic [16:0] divisor;
  logic        fits;
  logic [16:0] diff;
  logic [15:0] q_final;
  logic        blanked;

  assign shifted = {rem, quo[15]};
  assign divisor = {1'b0, last_period};
  assign fits    = (shifted >= divisor);
  assign diff    = shifted - divisor;

  assign stat.div_last = ctrl.div_step
                      && (step_cnt == eecs_pkg::STEP_W'(eecs_pkg::DIV_STEPS - 1));

  // zero period saturates to the numerator
  assign q_final = (last_period == '0) ? numerator : quo;
  assign blanked = stopped_mark || (last_period > eecs_pkg::PERIOD_LIMIT);

  // meter state
  always_ff @(posedge clk) begin
    if (rst) begin
      numerator      <= eecs_pkg::NUMERATOR_RESET;
      tick_count     <= '0;
      last_period    <= '0;
      last_direction <= 1'b0;
      meter_valid    <= 1'b0;
      stopped_mark   <= 1'b0;
    end else begin
      if (numerator_we) numerator <= numerator_wdata;
      if (ctrl.update) begin
        case (eecs_pkg::action_t'(action))
          eecs_pkg::ACT_CAPTURE: begin
            last_direction <= dir_pin;
            if (meter_valid) begin
              stopped_mark <= 1'b0;
              last_period  <= captured_period;
              tick_count   <= dir_pin ? tick_count + 24'd1 : tick_count - 24'd1;
            end else begin
              meter_valid <= 1'b1;
            end
          end
          eecs_pkg::ACT_SET_POS: tick_count <= {{5{new_position[15]}}, new_position, 3'b000};
          eecs_pkg::ACT_STOP:    stopped_mark <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // divider and result register
  always_ff @(posedge clk) begin
    if (ctrl.div_load) begin
      rem      <= '0;
      quo      <= numerator;
      step_cnt <= '0;
    end else if (ctrl.div_step) begin
      rem      <= fits ? diff[15:0] : shifted[15:0];
      quo      <= {quo[14:0], fits};
      step_cnt <= step_cnt + 1'b1;
    end
    if (ctrl.out_load) begin
      position   <= tick_count[18:3];
      is_stopped <= stopped_mark;
      if (blanked) begin
        signed_period <= eecs_pkg::PERIOD_LIMIT;
        speed         <= '0;
      end else if (last_direction) begin
        signed_period <= last_period;
        speed         <= {1'b0, q_final};
      end else begin
        signed_period <= 16'd0 - last_period;
        speed         <= 17'd0 - {1'b0, q_final};
      end
    end
  end

endmodule

// ----- src/encoder_edge_counter_speed.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder edge counter and speed meter
// Tracks wheel position from capture edges, keeps the last period and
// reports position, signed period and speed (numerator / period).
// ----------------------------------------------------------------------------
//  channel            dir  handshake        content
//  events             in   valid/ready      action, period, direction, position
//  results            out  valid/ready      position, period, speed, stopped
//  speed_numerator    in   write enable     16-bit speed numerator
//
//  Sequence: accept/state update, divider load, 16 restoring divider
//    steps, result register load; the next event beat is accepted only
//    once the result register is loaded.
//  Reset: synchronous; numerator returns to 32766, all meter state clears.
//  Stalls: a held result does not block the next event beat; only the
//    load of the next result waits for the output register to drain.
// ----------------------------------------------------------------------------
module encoder_edge_counter_speed (
  input  logic        clk,
  input  logic        rst,
  eecs_event_if.sink  events,
  eecs_result_if.source results,
  input  logic        speed_numerator_we,
  input  logic [15:0] speed_numerator
);

  eecs_pkg::ctrl_t ctrl;
  eecs_pkg::stat_t stat;

  // sequencer: idle -> load -> divide -> hand-off
  eecs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (events.valid),
    .in_ready  (events.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // meter state, divider and output payload register
  eecs_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .stat            (stat),
    .numerator_we    (speed_numerator_we),
    .numerator_wdata (speed_numerator),
    .action          (events.action),
    .captured_period (events.captured_period),
    .dir_pin         (events.dir_pin),
    .new_position    (events.new_position),
    .position        (results.position),
    .signed_period   (results.signed_period),
    .speed           (results.speed),
    .is_stopped      (results.is_stopped)
  );

endmodule

// ----- src/eecs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder meter port checker
// Watches the top-level ports of the meter.
// ----------------------------------------------------------------------------
module eecs_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [15:0] signed_period,
  input logic signed [16:0] speed,
  input logic              is_stopped
);

  // one event in flight: busy straight after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("event accepted while previous still in flight");

  // a result never appears in the cycle after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result raised too early");

  // stopped wheel reports the limit period and zero speed
  a_stopped_blank: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_stopped) |-> (signed_period == 16'sh7FFF && speed == 17'sd0))
    else $error("stopped result not blanked");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(speed) && $stable(signed_period)))
    else $error("stalled result changed");

  // after reset: ready for events, nothing to deliver
  a_reset_state: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("bad state after reset");

endmodule

bind encoder_edge_counter_speed eecs_checker u_eecs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (events.valid),
  .in_ready      (events.ready),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .signed_period (results.signed_period),
  .speed         (results.speed),
  .is_stopped    (results.is_stopped)
);
